// ===== hw/rtl/ris_pkg.sv =====
package ris_pkg;

    localparam int CAPACITY   = 32;
    localparam int ID_W       = 8;
    localparam int TIME_W     = 32;
    localparam int RANK_W     = 5;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W    = ID_W + TIME_W;
    localparam int IN_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int RES_W      = ID_W + TIME_W + RANK_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } seq_state_t;

    // Request from the sequencer to the record table.
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

endpackage

// ===== hw/rtl/ris_ram.sv =====
module ris_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ris_seq.sv =====
module ris_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ris_pkg::IN_TDATA_W-1:0]        in_data,
    input  logic                                  in_last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ris_pkg::OUT_TDATA_W-1:0]       out_data,
    output logic                                  out_last,
    output ris_pkg::ram_req_t                     ram_req,
    input  logic [ris_pkg::ENTRY_W-1:0]           ram_rdata
);
    import ris_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic [RES_W-1:0]   out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic [TIME_W-1:0]  rd_time;
    logic               key_greater;
    logic               can_load;
    logic               run_end;

    // The shared compare: one stored key against the incoming key per step.
    assign rd_time     = ram_rdata[ENTRY_W-1:ID_W];
    assign key_greater = time_reg > rd_time;
    assign can_load    = !out_valid_reg || out_ready;
    assign run_end     = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        id_reg       <= id_next;
        time_reg     <= time_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        id_next        = id_reg;
        time_next      = time_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_req        = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next   = in_data[ID_W-1:0];
                    time_next = in_data[ENTRY_W-1:ID_W];
                    last_next = in_last;
                    k_next    = '0;
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        // Table full: the record is dropped.
                        state_next = in_last ? ST_EMIT_RD : ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = ADDR_W'(count_reg);
                        state_next = (count_reg == '0) ? ST_PLACE : ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = pos_reg - ADDR_W'(1);
                state_next    = ST_SHIFT_CMP;
            end
            ST_SHIFT_CMP:
            begin
                if (key_greater)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = ram_rdata;
                    pos_next      = pos_reg - ADDR_W'(1);
                    state_next    = (pos_reg == ADDR_W'(1)) ? ST_PLACE : ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = {time_reg, id_reg};
                count_next    = count_reg + CNT_W'(1);
                state_next    = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = k_reg;
                state_next    = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {RANK_W'(k_reg), ram_rdata};
                    out_last_next  = run_end;
                    if (run_end)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_TDATA_W'(out_data_reg);
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/record_insertion_sorter_core.sv =====
// Channel   Direction  Fields
// s_axis    in         tdata: record_id, time_key; tlast: last_record
// m_axis    out        tdata: sorted_id, sorted_time, rank_position; tlast: final_result
//
// An insertion takes an accept step, a table read and then a compare for each stored
// record it is compared with, and a step to place it; at most 31 records are stored
// when a record is inserted. A record arriving at a full table is dropped on accept.
// Emitting a set reads, then loads out, each record, held while the output stalls; the
// input is not ready meanwhile. Reset clears the sequencer, the record count and the
// output valid flag; the table is not cleared, since only written entries are read.
module record_insertion_sorter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits from the lowest: record_id[7:0], time_key[39:8].
    input  logic [ris_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Bits from the lowest: sorted_id[7:0], sorted_time[39:8],
    // rank_position[44:40], then zero fill.
    output logic [ris_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import ris_pkg::*;

    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    // The table keeps records in descending time order, id in the low bits.
    ris_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // The sequencer owns the count, the shared key compare and the output register.
    ris_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // The table is only written while an item is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !s_axis_tready)
        else $error("table write while idle");

    // A result waiting for the receiver holds its valid flag and its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

    // The sequencer never reads and writes the table in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("table read and write together");

endmodule

// ===== sim/record_sorter_checker.sv =====
module record_sorter_checker
    import ris_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // Bits from the lowest: record_id, time_key.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Bits from the lowest: sorted_id, sorted_time, rank_position, zero fill.
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     mismatch_count,
    output int                     waiting_results,
    output int                     results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t;
        logic [RANK_W-1:0] rank;
        logic              is_last;
    } ranked_entry_t;

    // Shadow copy of the record table, kept in descending time order.
    logic [ID_W-1:0]   roster_ids   [CAPACITY];
    logic [TIME_W-1:0] roster_times [CAPACITY];
    int unsigned       roster_count;
    ranked_entry_t     ranked_q[$];

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // A new record goes below every stored record whose time is not smaller.
    task automatic insert_record(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t);
        int unsigned pos;
        if (roster_count >= CAPACITY)
        begin
            roster_count = CAPACITY;
            return;
        end
        pos = roster_count;
        while (pos != 0 && t > roster_times[pos-1])
        begin
            roster_ids[pos]   = roster_ids[pos-1];
            roster_times[pos] = roster_times[pos-1];
            pos--;
        end
        roster_ids[pos]   = id;
        roster_times[pos] = t;
        roster_count++;
    endtask

    task automatic release_sorted_run();
        ranked_entry_t e;
        for (int unsigned k = 0; k < roster_count; k++)
        begin
            e.id      = roster_ids[k];
            e.t       = roster_times[k];
            e.rank    = k[RANK_W-1:0];
            e.is_last = (k + 1 == roster_count);
            ranked_q.push_back(e);
        end
        roster_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        ranked_entry_t want;
        if (!rst_n)
        begin
            roster_count = 0;
            ranked_q.delete();
            waiting_results <= 0;
            results_seen    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                insert_record(s_axis_tdata[ID_W-1:0], s_axis_tdata[ID_W +: TIME_W]);
                if (s_axis_tlast)
                    release_sorted_run();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (ranked_q.size() == 0)
                begin
                    report_mismatch($sformatf("result id %0d time %0h with none pending",
                                              m_axis_tdata[ID_W-1:0],
                                              m_axis_tdata[ID_W +: TIME_W]));
                end
                else
                begin
                    want = ranked_q.pop_front();
                    if (m_axis_tdata[ID_W-1:0] !== want.id)
                        report_mismatch($sformatf("rank %0d sorted_id %0d, wanted %0d",
                                                  want.rank, m_axis_tdata[ID_W-1:0], want.id));
                    if (m_axis_tdata[ID_W +: TIME_W] !== want.t)
                        report_mismatch($sformatf("rank %0d sorted_time %0h, wanted %0h",
                                                  want.rank, m_axis_tdata[ID_W +: TIME_W],
                                                  want.t));
                    if (m_axis_tdata[ID_W + TIME_W +: RANK_W] !== want.rank)
                        report_mismatch($sformatf("rank_position %0d, wanted %0d",
                                                  m_axis_tdata[ID_W + TIME_W +: RANK_W],
                                                  want.rank));
                    if (m_axis_tlast !== want.is_last)
                        report_mismatch($sformatf("rank %0d final_result %0b, wanted %0b",
                                                  want.rank, m_axis_tlast, want.is_last));
                    if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0)
                        report_mismatch($sformatf("rank %0d fill bits not zero", want.rank));
                end
            end
            waiting_results <= ranked_q.size();
        end
    end

endmodule

// ===== sim/tb_record_insertion_sorter_core.sv =====
module tb_record_insertion_sorter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ris_pkg::*;

    // The run stops offering new sets once this many records have gone in.
    localparam int unsigned ITEM_TARGET      = 500;
    // From this record on, neither side idles.
    localparam int unsigned QUIET_FROM       = 440;
    // Cycles without any transfer before the run is declared hung. The slowest
    // legal gap is the long output hold-off plus a full-table insertion.
    localparam int unsigned STALL_LIMIT      = 4000;
    // Cycles to watch for stray results once nothing is pending.
    localparam int unsigned DRAIN_CYCLES     = 200;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int          HOLD_AFTER       = 40;

    typedef enum int {
        TIME_TIES,
        TIME_CORNERS,
        TIME_CLUSTER,
        TIME_SPREAD
    } time_style_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Bits from the lowest: record_id, time_key.
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Bits from the lowest: sorted_id, sorted_time, rank_position, zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int          mismatch_count;
    int          waiting_results;
    int          results_seen;
    int unsigned records_sent   = 0;
    bit          quiet_tail     = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned stall_cycles   = 0;

    always #1 clk = ~clk;

    record_insertion_sorter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker predicts every sorted run and compares it with what comes out.
    record_sorter_checker u_sort_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .mismatch_count  (mismatch_count),
        .waiting_results (waiting_results),
        .results_seen    (results_seen)
    );

    // Time keys are drawn in several styles so that ties, the extremes of the
    // unsigned range and dense clusters all show up in the sorted order.
    function automatic logic [TIME_W-1:0] pick_time(input time_style_t style);
        logic [TIME_W-1:0] corners [4];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        case (style)
            TIME_TIES:    return $urandom_range(0, 3);
            TIME_CORNERS: return corners[$urandom_range(0, 3)];
            TIME_CLUSTER: return 32'h4000_0000 + $urandom_range(0, 15);
            default:      return $urandom();
        endcase
    endfunction

    // Offers one record and returns at the edge where its transfer completes.
    // The valid flag stays high, so the next call simply replaces the data.
    task automatic send_record(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t,
                               input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, id};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        records_sent++;
        if (records_sent >= QUIET_FROM)
            quiet_tail = 1'b1;
    endtask

    // Idle gap on the input; the data lines carry junk while valid is low.
    task automatic pause_sender(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom(), 8'($urandom())};
        s_axis_tlast  <= 1'($urandom());
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the input off until every predicted result has been transferred.
    // The first edge is taken before looking, since the pending count is a registered
    // copy that lags the transfer that created it.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (waiting_results != 0);
    endtask

    // Most sets are short; some fill the table exactly and some overflow it,
    // so that late records are dropped and the last one still flushes the table.
    task automatic send_random_set();
        int unsigned set_len;
        int unsigned pick;
        time_style_t set_style;
        time_style_t style;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            set_len = $urandom_range(1, 8);
        else if (pick < 80)
            set_len = $urandom_range(9, CAPACITY - 1);
        else if (pick < 90)
            set_len = CAPACITY;
        else
            set_len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        set_style = time_style_t'($urandom_range(0, 3));
        for (int unsigned k = 0; k < set_len; k++)
        begin
            style = ($urandom_range(0, 3) == 0) ? time_style_t'($urandom_range(0, 3)) : set_style;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 19));
            send_record(8'($urandom()), pick_time(style), k + 1 == set_len);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A set of one record, at both extremes.
        send_record(8'h00, 32'h0000_0000, 1'b1);
        send_record(8'hFF, 32'hFFFF_FFFF, 1'b1);

        // Extreme values mixed, with a tie at the largest time that must land
        // after the record already stored.
        send_record(8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_record(8'h00, 32'h0000_0000, 1'b0);
        send_record(8'hAA, 32'hFFFF_FFFF, 1'b0);
        send_record(8'h55, 32'h8000_0000, 1'b0);
        send_record(8'h01, 32'h7FFF_FFFF, 1'b1);

        // All times equal: output order must be arrival order.
        for (int k = 0; k < 6; k++)
            send_record(8'(10 + k), 32'h0000_1234, k == 5);

        // Rising times: every new record walks to the top of the table.
        for (int k = 0; k < 6; k++)
            send_record(8'(20 + k), 32'(k + 1), k == 5);

        // Falling times: every new record stays at the bottom.
        for (int k = 0; k < 3; k++)
            send_record(8'(30 + k), 32'(9 - k), k == 2);

        // Let the directed sets come out completely before the random part.
        drain_results();

        while (records_sent < ITEM_TARGET)
            send_random_set();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off once the run is under
    // way so that a set backs up and the input stops accepting records.
    initial
    begin
        repeat (12) @(posedge clk);
        forever
        begin
            if (!long_hold_done && !quiet_tail && results_seen >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Hang detection: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
